// ===== rtl/assert_macros.svh =====
// Assertion helpers for the window mode filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, disabled during reset.
`define WMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

// ===== rtl/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants of the window mode filter
// Token carried along the counting chain, controller states, defaults.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int PIXEL_BITS     = 8;
  // Enough for a full window at the largest supported radius.
  localparam int CNT_BITS       = 6;

  localparam int CFG_BITS = 16;
  localparam logic [1:0] REG_IMG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_IMG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam int  RST_WIDTH  = 512;
  localparam int  RST_HEIGHT = 512;
  localparam int  RST_RADIUS = 1;

  typedef struct packed {
    logic                  vld;
    logic                  scan;
    logic [PIXEL_BITS-1:0] pix;
    logic [CNT_BITS-1:0]   best_cnt;
    logic [PIXEL_BITS-1:0] best_val;
  } wmf_tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_LAST,
    ST_DRAIN,
    ST_HOLD
  } wmf_state_t;

endpackage

// ===== rtl/window_mode_filter.sv =====
// ----------------------------------------------------------------------------
// window_mode_filter: streaming 2-D mode filter
// Outputs the most frequent intensity of the square window around each pixel.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on the in_ channel (in_req_type low);
// flush items (in_req_type high) drain outputs still pending after the last
// pixel. Each item yields at most one output on the out_ channel, flagged by
// out_last_of_frame on the final pixel of the frame. Registers on the cfg_
// port are to be written only while the block is idle; the block does not
// enforce this. A write to any of the three registers restarts the frame.
// Operation: an item that yields an output reads its N (1 to 49) in-image
// window pixels one per cycle from the line store; its scan token then
// crosses the counting chain, NCELL = (2*MAX_RADIUS+1)^2 cells long. The
// next item is taken only once the block is back in idle.
// The output register lets the next item be taken while a result waits; if
// the receiver stalls, the block holds its next result until the register
// frees. Reset clears the position counters and the chain; the line store is not
// cleared, as only pixels of the current frame are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module window_mode_filter import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_filtered_pixel,
  output logic                  out_last_of_frame
);

  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int RING  = 2 * MAX_RADIUS + 2;
  localparam int RB    = $clog2(RING);
  localparam int NCELL = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int DEPTH = RING * (2 ** XB);

  // Configuration registers
  logic [10:0] cfg_w_r;
  logic [15:0] cfg_h_r;
  logic [1:0]  cfg_rad_r;
  logic        restart;

  logic [WB-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [1:0]    rad_eff;

  assign w_eff   = (cfg_w_r == 11'd0) ? WB'(1) :
                   (32'(cfg_w_r) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(cfg_w_r);
  assign h_eff   = (cfg_h_r == 16'd0) ? 16'd1 : cfg_h_r;
  assign rad_eff = (32'(cfg_rad_r) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg_rad_r;

  assign restart = cfg_we && (cfg_index == REG_IMG_WIDTH || cfg_index == REG_IMG_HEIGHT ||
                              cfg_index == REG_WINDOW_RADIUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= 11'(RST_WIDTH);
      cfg_h_r   <= 16'(RST_HEIGHT);
      cfg_rad_r <= 2'(RST_RADIUS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH:     cfg_w_r   <= cfg_data[10:0];
        REG_IMG_HEIGHT:    cfg_h_r   <= cfg_data[15:0];
        REG_WINDOW_RADIUS: cfg_rad_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Controller
  wmf_state_t state_r, state_nxt;
  logic       in_acc, out_free, ready, walk_end, issue_vld, issue_scan, is_last;
  wmf_tok_t   head, tail;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    issue_vld  = 1'b0;
    issue_scan = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = ready ? ST_WALK : ST_IDLE;
      ST_WALK: begin
        issue_vld = 1'b1;
        if (walk_end) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        issue_vld  = 1'b1;
        issue_scan = 1'b1;
        state_nxt  = ST_DRAIN;
      end
      ST_DRAIN: if (tail.vld && tail.scan) state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Position counters
  logic [15:0]   in_row_r, out_row_r;
  logic [XB-1:0] in_col_r, out_col_r;
  logic [RB-1:0] in_ring_r, out_ring_r;
  logic          wr_en;

  assign wr_en   = in_acc && !in_req_type && (in_row_r < h_eff);
  assign is_last = (out_row_r == h_eff - 16'd1) && (WB'(out_col_r) == w_eff - WB'(1));

  always_ff @(posedge clk) begin
    if (!rst_n || restart || (state_r == ST_HOLD && out_free && is_last)) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else begin
      if (wr_en) begin
        if (WB'(in_col_r) + WB'(1) >= w_eff) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 16'd1;
          in_ring_r <= (32'(in_ring_r) == RING - 1) ? '0 : in_ring_r + RB'(1);
        end else begin
          in_col_r <= in_col_r + XB'(1);
        end
      end
      if (state_r == ST_HOLD && out_free) begin
        if (WB'(out_col_r) + WB'(1) >= w_eff) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + 16'd1;
          out_ring_r <= (32'(out_ring_r) == RING - 1) ? '0 : out_ring_r + RB'(1);
        end else begin
          out_col_r <= out_col_r + XB'(1);
        end
      end
    end
  end

  // Readiness and window bounds
  logic [16:0] need_r;
  logic [WB:0] need_c;
  logic [1:0]  k_up;
  logic [RB:0] ring0;
  logic [15:0] r0;
  logic [XB-1:0] c0;

  always_comb begin
    need_r = (17'(out_row_r) + 17'(rad_eff) < 17'(h_eff)) ?
             17'(out_row_r) + 17'(rad_eff) : 17'(h_eff) - 17'd1;
    need_c = ((WB+1)'(out_col_r) + (WB+1)'(rad_eff) < (WB+1)'(w_eff)) ?
             (WB+1)'(out_col_r) + (WB+1)'(rad_eff) : (WB+1)'(w_eff) - (WB+1)'(1);
    ready  = (out_row_r < h_eff) &&
             ((17'(in_row_r) > need_r) ||
              (17'(in_row_r) == need_r && (WB+1)'(in_col_r) > need_c));
    k_up   = (out_row_r >= 16'(rad_eff)) ? rad_eff : out_row_r[1:0];
    r0     = out_row_r - 16'(k_up);
    c0     = (out_col_r >= XB'(rad_eff)) ? out_col_r - XB'(rad_eff) : '0;
    ring0  = ((RB+1)'(out_ring_r) >= (RB+1)'(k_up)) ?
             (RB+1)'(out_ring_r) - (RB+1)'(k_up) :
             (RB+1)'(out_ring_r) + (RB+1)'(RING) - (RB+1)'(k_up);
  end

  // Window walk
  logic [15:0]   y_r, r1_r;
  logic [RB-1:0] yring_r;
  logic [XB-1:0] x_r, c0_r, c1_r;

  assign walk_end = (x_r == c1_r) && (y_r == r1_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      y_r     <= r0;
      yring_r <= ring0[RB-1:0];
      x_r     <= c0;
      c0_r    <= c0;
      c1_r    <= need_c[XB-1:0];
      r1_r    <= need_r[15:0];
    end else if (state_r == ST_WALK) begin
      if (x_r == c1_r) begin
        x_r     <= c0_r;
        y_r     <= y_r + 16'd1;
        yring_r <= (32'(yring_r) == RING - 1) ? '0 : yring_r + RB'(1);
      end else begin
        x_r <= x_r + XB'(1);
      end
    end
  end

  // Line store
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] mem_q_r;
  logic                  rd_vld_r, rd_scan_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[{in_ring_r, in_col_r}] <= in_pixel;
    mem_q_r <= mem[{yring_r, x_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      rd_scan_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue_vld;
      rd_scan_r <= issue_scan;
    end
  end

  always_comb begin
    head.vld      = rd_vld_r;
    head.scan     = rd_scan_r;
    head.pix      = mem_q_r;
    head.best_cnt = '0;
    head.best_val = '0;
  end

  wmf_chain #(.NCELL(NCELL)) u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .head (head),
    .tail (tail)
  );

  // Result and output register
  logic [PIXEL_BITS-1:0] res_r, out_pix_r;
  logic                  out_valid_r, out_last_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN && tail.vld && tail.scan) res_r <= tail.best_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_pix_r  <= res_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = out_pix_r;
  assign out_last_of_frame  = out_last_r;

  // Checks
  `WMF_ASSERT_NOW(a_scan_in_drain, tail.vld && tail.scan, state_r == ST_DRAIN)
  `WMF_ASSERT_NOW(a_no_pixel_overflow, tail.vld, tail.scan)
  `WMF_ASSERT_NEXT(a_hold_loads_out, state_r == ST_HOLD && out_free, out_valid_r)

endmodule

// ===== rtl/wmf_cell.sv =====
// ----------------------------------------------------------------------------
// wmf_cell: one histogram cell of the counting chain
// Holds one distinct intensity and its count. Pixel tokens are absorbed by a
// matching or empty cell; a scan token picks up the best entry and clears it.
// ----------------------------------------------------------------------------
module wmf_cell import wmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  wmf_tok_t tok_in,
  output wmf_tok_t tok_out
);

  logic                  occ_r, occ_nxt;
  logic [PIXEL_BITS-1:0] val_r, val_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  wmf_tok_t              tok_r, tok_nxt;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.scan) begin
      if (occ_r && val_r == tok_in.pix) begin
        cnt_nxt     = cnt_r + CNT_BITS'(1);
        tok_nxt.vld = 1'b0;
      end else if (!occ_r) begin
        occ_nxt     = 1'b1;
        val_nxt     = tok_in.pix;
        cnt_nxt     = CNT_BITS'(1);
        tok_nxt.vld = 1'b0;
      end
    end else if (tok_in.vld && tok_in.scan) begin
      // Higher count wins; on equal counts the higher intensity wins.
      if (occ_r && (cnt_r > tok_in.best_cnt ||
                    (cnt_r == tok_in.best_cnt && val_r > tok_in.best_val))) begin
        tok_nxt.best_cnt = cnt_r;
        tok_nxt.best_val = val_r;
      end
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    val_r         <= val_nxt;
    cnt_r         <= cnt_nxt;
    tok_r.scan     <= tok_nxt.scan;
    tok_r.pix      <= tok_nxt.pix;
    tok_r.best_cnt <= tok_nxt.best_cnt;
    tok_r.best_val <= tok_nxt.best_val;
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/wmf_chain.sv =====
// ----------------------------------------------------------------------------
// wmf_chain: row of histogram cells
// Tokens move one cell per cycle; the scan token leaves the tail with the mode.
// ----------------------------------------------------------------------------
module wmf_chain import wmf_pkg::*; #(
  parameter int NCELL = 49
) (
  input  logic     clk,
  input  logic     rst_n,
  input  wmf_tok_t head,
  output wmf_tok_t tail
);

  wmf_tok_t link [NCELL+1];

  assign link[0] = head;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    wmf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (link[i]),
      .tok_out(link[i+1])
    );
  end

  assign tail = link[NCELL];

endmodule
